>>> hdl/plid_pkg.sv
// Shared types and codes for the positional list block.
package plid_pkg;

  // Command codes carried on the cmd port
  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AFTER = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_POS = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Internal operation picked when a command is decoded
  typedef enum logic [1:0] {
    OP_FRONT = 2'd0,
    OP_BACK  = 2'd1,
    OP_AFTER = 2'd2,
    OP_DEL   = 2'd3
  } op_t;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_WALK   = 6'b000010,
    S_READ   = 6'b000100,
    S_LINK1  = 6'b001000,
    S_LINK2  = 6'b010000,
    S_UNLINK = 6'b100000
  } state_t;

endpackage

>>> hdl/plid_ram.sv
// Generic single-write, single-read RAM with registered read data.
module plid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port (read returns old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/positional_list_insert_delete.sv
// Top level: bounded doubly linked list with positional insert and delete.
//
// Usage:
//   A command transaction is taken at a rising edge where start is high and
//   busy is low; cmd, value and position are sampled at that edge.
//   Exactly one result per command appears on status, removed_value and
//   length, marked by done for one cycle. The receiver cannot stall it.
//   Steps from the accepting edge to the done cycle: full, empty and
//   invalid results are issued straight from idle; insert front/back
//   takes and links a slot in S_LINK1; delete front/back reads the
//   element in S_READ, then unlinks it in S_UNLINK; delete at p walks
//   the links in S_WALK to element p, then unlinks it; insert after p
//   walks to element p, then links in S_LINK1, adding S_LINK2 to
//   relink the successor when p is inside the list, not the tail.
//   The link walk moves one element per cycle through the next-link RAM's
//   registered read port; busy stays high until the result is issued, and
//   a new command may be taken in the done cycle.
//   Free slots come from a stack RAM plus a fill counter, so no clearing
//   pass is needed. Reset (rst, synchronous) empties the list at once.
module positional_list_insert_delete
  import plid_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [2:0]                             cmd,
  input  logic signed [VALUE_BITS-1:0]           value,
  input  logic [$clog2(CAPACITY+1)-1:0]          position,
  output logic                                   done,
  output logic [1:0]                             status,
  output logic signed [VALUE_BITS-1:0]           removed_value,
  output logic [$clog2(CAPACITY+1)-1:0]          length
);

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);
  localparam logic [LW-1:0] ONE_L = LW'(1);

  // Control state
  state_t         state;
  op_t            op;
  logic           pend;
  logic [LW-1:0]  cnt;
  logic [IW-1:0]  head;
  logic [IW-1:0]  tail;
  logic [LW-1:0]  count;
  logic [LW-1:0]  fill;
  logic [LW-1:0]  sp;

  // Payload registers
  logic [IW-1:0]         cur;
  logic [IW-1:0]         new_slot;
  logic [IW-1:0]         succ;
  logic [VALUE_BITS-1:0] val_r;

  // RAM ports
  logic                  el_we, nx_we, pv_we, fr_we;
  logic [IW-1:0]         el_waddr, nx_waddr, pv_waddr;
  logic [VALUE_BITS-1:0] el_wdata, el_dout;
  logic [IW-1:0]         nx_wdata, pv_wdata, nx_dout, pv_dout, fr_dout;
  logic [IW-1:0]         rd_slot, fr_raddr;

  // Derived
  logic [IW-1:0] cur_eff;
  logic [IW-1:0] alloc_slot;
  logic          at_tail;
  logic          mid_unlink;

  // Command decode
  state_t        dec_state;
  op_t           dec_op;
  status_t       dec_status;
  logic [IW-1:0] dec_slot;

  assign busy       = (state != S_IDLE);
  assign cur_eff    = pend ? nx_dout : cur;
  assign rd_slot    = (state == S_WALK) ? cur_eff : cur;
  assign alloc_slot = (sp != '0) ? fr_dout : fill[IW-1:0];
  assign fr_raddr   = IW'(sp - ONE_L);
  assign at_tail    = (cur == tail);
  assign mid_unlink = (count > ONE_L) && (cur != head) && (cur != tail);

  // Decode of an incoming command transaction
  always_comb begin
    dec_state  = S_IDLE;
    dec_op     = OP_FRONT;
    dec_status = ST_OK;
    dec_slot   = head;
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AFTER: begin
        if (count >= CAP_L) begin
          dec_status = ST_FULL;
        end else if (cmd == CMD_INS_BACK) begin
          dec_op    = OP_BACK;
          dec_state = S_LINK1;
        end else if (cmd == CMD_INS_FRONT || position == '0 ||
                     (count == '0 && position == ONE_L)) begin
          dec_op    = OP_FRONT;
          dec_state = S_LINK1;
        end else if (position > count) begin
          dec_status = ST_BAD_POS;
        end else begin
          dec_op    = OP_AFTER;
          dec_state = S_WALK;
        end
      end
      CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
        dec_op = OP_DEL;
        if (count == '0) begin
          dec_status = ST_EMPTY;
        end else if (cmd == CMD_DEL_FRONT) begin
          dec_state = S_READ;
        end else if (cmd == CMD_DEL_BACK) begin
          dec_state = S_READ;
          dec_slot  = tail;
        end else if (position == '0 || position > count) begin
          dec_status = ST_BAD_POS;
        end else begin
          dec_state = S_WALK;
        end
      end
      default: dec_status = ST_BAD_POS;
    endcase
  end

  // RAM write steering per sequencer step
  always_comb begin
    el_we    = 1'b0;
    el_waddr = alloc_slot;
    el_wdata = val_r;
    nx_we    = 1'b0;
    nx_waddr = alloc_slot;
    nx_wdata = head;
    pv_we    = 1'b0;
    pv_waddr = alloc_slot;
    pv_wdata = tail;
    fr_we    = 1'b0;
    case (state)
      S_LINK1: begin
        el_we = 1'b1;
        if (op == OP_FRONT) begin
          nx_we = 1'b1;
          if (count != '0) begin
            pv_we    = 1'b1;
            pv_waddr = head;
            pv_wdata = alloc_slot;
          end
        end else if (op == OP_BACK || at_tail) begin
          pv_we = 1'b1;
          if (count != '0) begin
            nx_we    = 1'b1;
            nx_waddr = tail;
            nx_wdata = alloc_slot;
          end
        end else begin
          nx_we    = 1'b1;
          nx_wdata = nx_dout;
          pv_we    = 1'b1;
          pv_wdata = cur;
        end
      end
      S_LINK2: begin
        nx_we    = 1'b1;
        nx_waddr = cur;
        nx_wdata = new_slot;
        pv_we    = 1'b1;
        pv_waddr = succ;
        pv_wdata = new_slot;
      end
      S_UNLINK: begin
        fr_we = 1'b1;
        if (mid_unlink) begin
          nx_we    = 1'b1;
          nx_waddr = pv_dout;
          nx_wdata = nx_dout;
          pv_we    = 1'b1;
          pv_waddr = nx_dout;
          pv_wdata = pv_dout;
        end
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      op     <= OP_FRONT;
      pend   <= 1'b0;
      cnt    <= '0;
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      fill   <= '0;
      sp     <= '0;
      done   <= 1'b0;
      status <= ST_OK;
      length <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= dec_state;
            op    <= dec_op;
            cur   <= dec_slot;
            cnt   <= position - ONE_L;
            pend  <= 1'b0;
            val_r <= value;
            if (dec_state == S_IDLE) begin
              done          <= 1'b1;
              status        <= dec_status;
              removed_value <= '0;
              length        <= count;
            end
          end
        end
        // One link per cycle; the last cycle also reads the target's links
        S_WALK: begin
          pend <= 1'b1;
          if (cnt == '0) begin
            cur   <= cur_eff;
            state <= (op == OP_DEL) ? S_UNLINK : S_LINK1;
          end else begin
            cnt <= cnt - ONE_L;
          end
        end
        S_READ: begin
          state <= S_UNLINK;
        end
        // Take a slot, write it and link it in
        S_LINK1: begin
          if (sp != '0) begin
            sp <= sp - ONE_L;
          end else begin
            fill <= fill + ONE_L;
          end
          if (op == OP_FRONT) begin
            head <= alloc_slot;
            if (count == '0) begin
              tail <= alloc_slot;
            end
          end else if (op == OP_BACK || at_tail) begin
            tail <= alloc_slot;
            if (count == '0) begin
              head <= alloc_slot;
            end
          end
          if (op == OP_AFTER && !at_tail) begin
            new_slot <= alloc_slot;
            succ     <= nx_dout;
            state    <= S_LINK2;
          end else begin
            count         <= count + ONE_L;
            done          <= 1'b1;
            status        <= ST_OK;
            removed_value <= '0;
            length        <= count + ONE_L;
            state         <= S_IDLE;
          end
        end
        S_LINK2: begin
          count         <= count + ONE_L;
          done          <= 1'b1;
          status        <= ST_OK;
          removed_value <= '0;
          length        <= count + ONE_L;
          state         <= S_IDLE;
        end
        // Unhook the element and return its slot to the free stack
        S_UNLINK: begin
          if (count <= ONE_L) begin
            head <= '0;
            tail <= '0;
          end else if (cur == head) begin
            head <= nx_dout;
          end else if (cur == tail) begin
            tail <= pv_dout;
          end
          sp            <= sp + ONE_L;
          count         <= count - ONE_L;
          done          <= 1'b1;
          status        <= ST_OK;
          removed_value <= el_dout;
          length        <= count - ONE_L;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Storage
  plid_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_elem (
    .clk(clk), .we(el_we), .waddr(el_waddr), .wdata(el_wdata),
    .raddr(rd_slot), .rdata(el_dout)
  );

  plid_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(rd_slot), .rdata(nx_dout)
  );

  plid_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(rd_slot), .rdata(pv_dout)
  );

  plid_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_free (
    .clk(clk), .we(fr_we), .waddr(sp[IW-1:0]), .wdata(cur),
    .raddr(fr_raddr), .rdata(fr_dout)
  );

  // Checks
  // Every slot ever handed out is linked, on the free stack, or being linked
  assert property (@(posedge clk) disable iff (rst)
    ((LW+1)'(count) + (LW+1)'(sp) + (LW+1)'(state == S_LINK2)) == (LW+1)'(fill))
    else $error("slot accounting mismatch");

  // An accepted transaction either answers at once or keeps the block busy
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("command transaction dropped");

  // A full status only with the list at capacity
  assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (length == CAP_L))
    else $error("full reported below capacity");

  // Only a successful delete returns a value
  assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (removed_value == '0))
    else $error("value returned on failed command");

endmodule
